### rtl/apd_pkg.sv
// shared types, constants and codes for the all-pairs hop distance block
package apd_pkg;

    // default vertex capacity of the distance matrix
    localparam int MaxVertices = 64;

    // distance entry width and the code for no path
    localparam int DistW = 7;
    localparam logic [DistW-1:0] DIST_INF = 7'd127;

    // field widths fixed by the interface
    localparam int VcW  = 7;
    localparam int EccW = 6;

    // command codes
    typedef enum logic {
        CMD_EDGE = 1'b0,
        CMD_RUN  = 1'b1
    } t_cmd;

    // one input beat
    typedef struct packed {
        t_cmd           cmd;
        logic [VcW-1:0] edge_from;
        logic [VcW-1:0] edge_to;
    } t_apd_in;

    // one result beat
    typedef struct packed {
        logic [VcW-1:0]  vertex;
        logic [EccW-1:0] eccentricity;
        logic            reaches_any;
        logic            last;
    } t_apd_out;

    // operations of the shared compare-add unit
    typedef enum logic {
        ALU_RELAX = 1'b0,
        ALU_MAX   = 1'b1
    } t_alu_op;

    // result of the shared compare-add unit
    typedef struct packed {
        logic             take;
        logic             finite;
        logic [DistW-1:0] value;
    } t_alu_res;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE2,
        ST_FW_DUK,
        ST_FW_LAT,
        ST_FW_ROW,
        ST_FW_DRAIN,
        ST_ECC,
        ST_ECC_DRAIN
    } t_apd_state;

endpackage

### rtl/apd_dmem.sv
// distance matrix memory: one write port, two registered read ports
module apd_dmem #(
    parameter  int DEPTH = apd_pkg::MaxVertices * apd_pkg::MaxVertices,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [apd_pkg::DistW-1:0]  i_wdata,
    input  logic [AW-1:0]              i_raddr_a,
    input  logic [AW-1:0]              i_raddr_b,
    output logic [apd_pkg::DistW-1:0]  o_rdata_a,
    output logic [apd_pkg::DistW-1:0]  o_rdata_b
);

    logic [apd_pkg::DistW-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### rtl/apd_alu.sv
// shared compare-add unit: path relaxation and running maximum
module apd_alu (
    input  apd_pkg::t_alu_op           i_op,
    input  logic [apd_pkg::DistW-1:0]  i_a,
    input  logic [apd_pkg::DistW-1:0]  i_b,
    input  logic [apd_pkg::DistW-1:0]  i_c,
    output apd_pkg::t_alu_res          o_res
);

    logic [apd_pkg::DistW:0] sum;
    logic                    a_fin;
    logic                    b_fin;

    assign sum   = {1'b0, i_a} + {1'b0, i_b};
    assign a_fin = (i_a != apd_pkg::DIST_INF);
    assign b_fin = (i_b != apd_pkg::DIST_INF);

    // relax: a + b against c; max: a against c
    always_comb begin
        unique case (i_op)
            apd_pkg::ALU_RELAX: begin
                o_res.finite = a_fin && b_fin;
                o_res.take   = a_fin && b_fin
                               && (sum < {1'b0, apd_pkg::DIST_INF})
                               && (sum[apd_pkg::DistW-1:0] < i_c);
                o_res.value  = sum[apd_pkg::DistW-1:0];
            end
            apd_pkg::ALU_MAX: begin
                o_res.finite = a_fin;
                o_res.take   = a_fin && (i_a > i_c);
                o_res.value  = i_a;
            end
            default: begin
                o_res.finite = 1'b0;
                o_res.take   = 1'b0;
                o_res.value  = i_a;
            end
        endcase
    end

endmodule

### rtl/apd_seq.sv
// sequencer: clearing sweep, edge loads, relaxation walk and eccentricity scan
module apd_seq #(
    parameter  int MAX_VERTICES = apd_pkg::MaxVertices,
    localparam int AW           = $clog2(MAX_VERTICES * MAX_VERTICES)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  apd_pkg::t_apd_in           i_item,
    output logic                       o_busy,
    input  logic                       i_cfg_valid,
    input  logic [apd_pkg::VcW-1:0]    i_cfg_data,
    output logic                       o_we,
    output logic [AW-1:0]              o_waddr,
    output logic [apd_pkg::DistW-1:0]  o_wdata,
    output logic [AW-1:0]              o_raddr_a,
    output logic [AW-1:0]              o_raddr_b,
    input  logic [apd_pkg::DistW-1:0]  i_rdata_a,
    input  logic [apd_pkg::DistW-1:0]  i_rdata_b,
    output logic                       o_res_valid,
    output apd_pkg::t_apd_out          o_res
);

    localparam int IDXW = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int EW   = (CW > apd_pkg::VcW) ? CW : apd_pkg::VcW;
    localparam logic [IDXW-1:0] TopIdx = IDXW'(MAX_VERTICES - 1);

    apd_pkg::t_apd_state       r_state, n_state;
    logic [IDXW-1:0]           r_k, n_k;
    logic [IDXW-1:0]           r_u, n_u;
    logic [IDXW-1:0]           r_v, n_v;
    logic                      r_p_valid, n_p_valid;
    logic [IDXW-1:0]           r_p_u, n_p_u;
    logic [IDXW-1:0]           r_p_v, n_p_v;
    logic [apd_pkg::DistW-1:0] r_duk, n_duk;
    logic [apd_pkg::DistW-1:0] r_best, n_best;
    logic                      r_any, n_any;
    logic [CW-1:0]             r_n, n_n;
    logic                      r_res_valid, n_res_valid;
    apd_pkg::t_apd_out         r_res, n_res;

    logic [IDXW-1:0]           last_idx;
    logic                      ecc_mode;
    logic                      from_ok;
    logic                      to_ok;
    logic [IDXW-1:0]           from_idx;
    logic [IDXW-1:0]           to_idx;
    logic [apd_pkg::DistW-1:0] best_in;
    logic                      any_in;
    logic                      pair_ok;
    apd_pkg::t_alu_op          alu_op;
    logic [apd_pkg::DistW-1:0] alu_a;
    logic [apd_pkg::DistW-1:0] alu_c;
    apd_pkg::t_alu_res         alu_res;

    // flat matrix address of a row and column
    function automatic logic [AW-1:0] f_addr(input logic [IDXW-1:0] row,
                                             input logic [IDXW-1:0] col);
        f_addr = AW'(row) * AW'(MAX_VERTICES) + AW'(col);
    endfunction

    // saturated vertex count for a configuration write
    always_comb begin
        if (i_cfg_data == '0) begin
            n_n = CW'(1);
        end else if (EW'(i_cfg_data) > EW'(MAX_VERTICES)) begin
            n_n = CW'(MAX_VERTICES);
        end else begin
            n_n = CW'(i_cfg_data);
        end
    end

    // edge endpoint checks
    assign from_ok  = (i_item.edge_from != '0) && (EW'(i_item.edge_from) <= EW'(r_n));
    assign to_ok    = (i_item.edge_to != '0) && (EW'(i_item.edge_to) <= EW'(r_n));
    assign from_idx = IDXW'(EW'(i_item.edge_from) - EW'(1));
    assign to_idx   = IDXW'(EW'(i_item.edge_to) - EW'(1));
    assign last_idx = IDXW'(r_n - CW'(1));

    // second stage operands for the shared unit
    assign ecc_mode = (r_state == apd_pkg::ST_ECC) || (r_state == apd_pkg::ST_ECC_DRAIN);
    assign best_in  = (r_p_u == '0) ? '0 : r_best;
    assign any_in   = (r_p_u == '0) ? 1'b0 : r_any;
    assign pair_ok  = (r_p_u != r_p_v);
    assign alu_op   = ecc_mode ? apd_pkg::ALU_MAX : apd_pkg::ALU_RELAX;
    assign alu_a    = ecc_mode ? i_rdata_b : r_duk;
    assign alu_c    = ecc_mode ? best_in : i_rdata_b;

    apd_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (i_rdata_a),
        .i_c   (alu_c),
        .o_res (alu_res)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apd_pkg::ST_CLEAR;
            r_k         <= '0;
            r_u         <= '0;
            r_v         <= '0;
            r_p_valid   <= 1'b0;
            r_res_valid <= 1'b0;
            r_n         <= CW'(MAX_VERTICES);
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_u         <= n_u;
            r_v         <= n_v;
            r_p_valid   <= n_p_valid;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid) begin
                r_n <= n_n;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_p_u  <= n_p_u;
        r_p_v  <= n_p_v;
        r_duk  <= n_duk;
        r_best <= n_best;
        r_any  <= n_any;
        r_res  <= n_res;
    end

    // next state, memory requests and second stage
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_u         = r_u;
        n_v         = r_v;
        n_p_valid   = 1'b0;
        n_p_u       = r_p_u;
        n_p_v       = r_p_v;
        n_duk       = r_duk;
        n_best      = r_best;
        n_any       = r_any;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_we        = 1'b0;
        o_waddr     = f_addr(r_u, r_v);
        o_wdata     = apd_pkg::DIST_INF;
        o_raddr_a   = f_addr(r_u, r_k);
        o_raddr_b   = f_addr(r_u, r_v);

        unique case (r_state)
            // sweep the matrix back to the no-edge state
            apd_pkg::ST_CLEAR: begin
                o_we    = 1'b1;
                o_wdata = (r_u == r_v) ? '0 : apd_pkg::DIST_INF;
                if (r_v == TopIdx) begin
                    n_v = '0;
                    if (r_u == TopIdx) begin
                        n_u     = '0;
                        n_state = apd_pkg::ST_IDLE;
                    end else begin
                        n_u = r_u + IDXW'(1);
                    end
                end else begin
                    n_v = r_v + IDXW'(1);
                end
            end
            // take a command
            apd_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_item.cmd == apd_pkg::CMD_RUN) begin
                        n_k     = '0;
                        n_u     = '0;
                        n_v     = '0;
                        n_state = apd_pkg::ST_FW_DUK;
                    end else if (from_ok && to_ok && (from_idx != to_idx)) begin
                        o_we    = 1'b1;
                        o_waddr = f_addr(from_idx, to_idx);
                        o_wdata = apd_pkg::DistW'(1);
                        n_u     = to_idx;
                        n_v     = from_idx;
                        n_state = apd_pkg::ST_EDGE2;
                    end
                end
            end
            // mirrored entry of the edge
            apd_pkg::ST_EDGE2: begin
                o_we    = 1'b1;
                o_wdata = apd_pkg::DistW'(1);
                n_u     = '0;
                n_v     = '0;
                n_state = apd_pkg::ST_IDLE;
            end
            // fetch the leg from row u to pivot k
            apd_pkg::ST_FW_DUK: begin
                o_raddr_a = f_addr(r_u, r_k);
                n_state   = apd_pkg::ST_FW_LAT;
            end
            apd_pkg::ST_FW_LAT: begin
                n_duk   = i_rdata_a;
                n_state = apd_pkg::ST_FW_ROW;
            end
            // stream one row of relaxations through the shared unit
            apd_pkg::ST_FW_ROW: begin
                o_raddr_a = f_addr(r_k, r_v);
                o_raddr_b = f_addr(r_u, r_v);
                n_p_valid = 1'b1;
                n_p_u     = r_u;
                n_p_v     = r_v;
                if (r_v == last_idx) begin
                    n_v     = '0;
                    n_state = apd_pkg::ST_FW_DUK;
                    if (r_u == last_idx) begin
                        n_u = '0;
                        if (r_k == last_idx) begin
                            n_k     = '0;
                            n_state = apd_pkg::ST_FW_DRAIN;
                        end else begin
                            n_k = r_k + IDXW'(1);
                        end
                    end else begin
                        n_u = r_u + IDXW'(1);
                    end
                end else begin
                    n_v = r_v + IDXW'(1);
                end
            end
            apd_pkg::ST_FW_DRAIN: begin
                n_state = apd_pkg::ST_ECC;
            end
            // scan column v for its largest finite distance
            apd_pkg::ST_ECC: begin
                o_raddr_b = f_addr(r_u, r_v);
                n_p_valid = 1'b1;
                n_p_u     = r_u;
                n_p_v     = r_v;
                if (r_u == last_idx) begin
                    n_u = '0;
                    if (r_v == last_idx) begin
                        n_v     = '0;
                        n_state = apd_pkg::ST_ECC_DRAIN;
                    end else begin
                        n_v = r_v + IDXW'(1);
                    end
                end else begin
                    n_u = r_u + IDXW'(1);
                end
            end
            apd_pkg::ST_ECC_DRAIN: begin
                n_u     = '0;
                n_v     = '0;
                n_state = apd_pkg::ST_CLEAR;
            end
            default: begin
                n_u     = '0;
                n_v     = '0;
                n_state = apd_pkg::ST_CLEAR;
            end
        endcase

        // relaxation write-back
        if (r_p_valid && !ecc_mode && alu_res.take) begin
            o_we    = 1'b1;
            o_waddr = f_addr(r_p_u, r_p_v);
            o_wdata = alu_res.value;
        end

        // running maximum and result beat
        if (r_p_valid && ecc_mode) begin
            n_best = (pair_ok && alu_res.take) ? alu_res.value : best_in;
            n_any  = any_in | (pair_ok & alu_res.finite);
            if (r_p_u == last_idx) begin
                n_res_valid            = 1'b1;
                n_res.vertex           = apd_pkg::VcW'(EW'(r_p_v) + EW'(1));
                n_res.eccentricity     = n_any ? n_best[apd_pkg::EccW-1:0] : '0;
                n_res.reaches_any      = n_any;
                n_res.last             = (r_p_v == last_idx);
            end
        end
    end

    assign o_busy      = (r_state != apd_pkg::ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

### rtl/all_pairs_hop_distance_eccentricity_top.sv
// top level of the all-pairs hop distance and eccentricity block
//
// usage: write vertex_count on the cfg channel (valid/ready, always ready) while
// idle. A command beat is taken when i_start is high and o_busy is low. An edge
// command stores both matrix entries, in ST_IDLE and then ST_EDGE2, and emits
// nothing; endpoints out of range or equal are dropped. A run command relaxes
// the matrix with one compare-add unit and one memory with two read ports,
// walking over pivots and rows (each row first fetches the leg to the pivot
// in ST_FW_DUK and ST_FW_LAT), then scanning columns, which sends one result
// beat per vertex, o_res_valid high for exactly one cycle, last set on the
// final vertex. The receiver cannot stall; every beat must be taken as shown.
// After a run, and after reset, a clearing sweep writes the whole matrix of
// MAX_VERTICES*MAX_VERTICES entries, one a cycle, with o_busy high; config
// writes are still taken. Reset is synchronous, active low, and sets the vertex
// count to MAX_VERTICES.
module all_pairs_hop_distance_eccentricity_top #(
    parameter int MAX_VERTICES = apd_pkg::MaxVertices
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  apd_pkg::t_apd_in         i_item,
    output logic                     o_busy,
    output logic                     o_res_valid,
    output apd_pkg::t_apd_out        o_res,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [apd_pkg::VcW-1:0]  i_cfg_data
);

    localparam int Depth = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(Depth);

    logic                      we;
    logic [AW-1:0]             waddr;
    logic [apd_pkg::DistW-1:0] wdata;
    logic [AW-1:0]             raddr_a;
    logic [AW-1:0]             raddr_b;
    logic [apd_pkg::DistW-1:0] rdata_a;
    logic [apd_pkg::DistW-1:0] rdata_b;

    // config register is written in any state
    assign o_cfg_ready = 1'b1;

    // sequencer with the shared unit
    apd_seq #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_item      (i_item),
        .o_busy      (o_busy),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // distance matrix
    apd_dmem #(
        .DEPTH (Depth)
    ) u_dmem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // result beats only come out of a run in progress
    a_res_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_busy)
        else $error("result beat while idle");

    // the final result is followed by the clearing sweep, not another beat
    a_last_then_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> (!o_res_valid && o_busy))
        else $error("beat or idle straight after the final result");

    // an accepted run command always occupies the block
    a_run_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_item.cmd == apd_pkg::CMD_RUN)) |=> o_busy)
        else $error("run command accepted without going busy");

endmodule

### tb/sv/hop_eccentricity_checker.sv
// checker for the hop distance block: own distance matrix, eccentricity prediction, compare
`timescale 1ns / 100ps

module hop_eccentricity_checker
    import apd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  t_apd_in        i_item,
    input  logic           i_busy,
    input  logic           i_res_valid,
    input  t_apd_out       i_res,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_ready,
    input  logic [VcW-1:0] i_cfg_data,
    output int             o_mismatch_count,
    output int             o_pending
);

    // shadow of the distance matrix and of the vertex count register
    logic [DistW-1:0] hop_dist [MaxVertices][MaxVertices];
    logic [VcW-1:0]   vertex_count_reg;

    // eccentricity beats still owed by the block, oldest first
    t_apd_out         ecc_expect_q [$];

    // vertex count as the block uses it: zero acts as one, saturates at capacity
    function automatic int live_vertices();
        if (vertex_count_reg < 1) return 1;
        if (vertex_count_reg > MaxVertices) return MaxVertices;
        return int'(vertex_count_reg);
    endfunction

    // no-edge state: infinity everywhere, zero on the diagonal
    function automatic void clear_hops();
        for (int r = 0; r < MaxVertices; r++) begin
            for (int c = 0; c < MaxVertices; c++) begin
                hop_dist[r][c] = (r == c) ? '0 : DIST_INF;
            end
        end
    endfunction

    // both directed entries of an in-range, non-loop edge go to one hop
    function automatic void store_edge(input t_apd_in beat);
        int n;
        int a;
        int b;
        n = live_vertices();
        a = int'(beat.edge_from);
        b = int'(beat.edge_to);
        if (a >= 1 && a <= n && b >= 1 && b <= n && a != b) begin
            hop_dist[a-1][b-1] = 7'd1;
            hop_dist[b-1][a-1] = 7'd1;
        end
    endfunction

    // relax over pivots, then queue one eccentricity beat per vertex
    function automatic void predict_eccentricities();
        int       n;
        int       sum;
        int       best;
        bit       any;
        t_apd_out beat;
        n = live_vertices();
        for (int k = 0; k < n; k++) begin
            for (int u = 0; u < n; u++) begin
                if (hop_dist[u][k] == DIST_INF) continue;
                for (int v = 0; v < n; v++) begin
                    if (hop_dist[k][v] == DIST_INF) continue;
                    sum = int'(hop_dist[u][k]) + int'(hop_dist[k][v]);
                    if (sum < int'(DIST_INF) && sum < int'(hop_dist[u][v]))
                        hop_dist[u][v] = DistW'(sum);
                end
            end
        end
        // column scan: largest finite distance from any other vertex
        for (int v = 0; v < n; v++) begin
            best = 0;
            any  = 1'b0;
            for (int u = 0; u < n; u++) begin
                if (u == v) continue;
                if (hop_dist[u][v] != DIST_INF) begin
                    if (!any || int'(hop_dist[u][v]) > best) best = int'(hop_dist[u][v]);
                    any = 1'b1;
                end
            end
            beat.vertex       = VcW'(v + 1);
            beat.eccentricity = any ? EccW'(best) : '0;
            beat.reaches_any  = any;
            beat.last         = (v + 1 == n);
            ecc_expect_q.insert(ecc_expect_q.size(), beat);
        end
        clear_hops();
    endfunction

    // one line per mismatch, counted
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        o_mismatch_count++;
    endtask

    // compare a result beat field by field with the oldest expectation
    task automatic check_result(input t_apd_out got);
        t_apd_out want;
        if (ecc_expect_q.size() == 0) begin
            report_mismatch($sformatf("result beat for vertex %0d with nothing expected",
                                      got.vertex));
            return;
        end
        want = ecc_expect_q.pop_front();
        if (got.vertex != want.vertex)
            report_mismatch($sformatf("vertex: got %0d, want %0d", got.vertex, want.vertex));
        if (got.eccentricity != want.eccentricity)
            report_mismatch($sformatf("vertex %0d eccentricity: got %0d, want %0d",
                                      want.vertex, got.eccentricity, want.eccentricity));
        if (got.reaches_any != want.reaches_any)
            report_mismatch($sformatf("vertex %0d reaches_any: got %0b, want %0b",
                                      want.vertex, got.reaches_any, want.reaches_any));
        if (got.last != want.last)
            report_mismatch($sformatf("vertex %0d last: got %0b, want %0b",
                                      want.vertex, got.last, want.last));
    endtask

    // watch every channel at the clock edge; a count written at this edge applies afterwards
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_hops();
            vertex_count_reg = VcW'(MaxVertices);
            ecc_expect_q.delete();
            o_mismatch_count = 0;
        end else begin
            if (i_res_valid) check_result(i_res);
            if (i_start && !i_busy) begin
                if (i_item.cmd == CMD_RUN) predict_eccentricities();
                else store_edge(i_item);
            end
            if (i_cfg_valid && i_cfg_ready) vertex_count_reg = i_cfg_data;
        end
        o_pending <= ecc_expect_q.size();
    end

endmodule

### tb/sv/tb_top.sv
// top of the hop distance testbench: clock, reset, command and config stimulus, verdict
`timescale 1ns / 100ps

module tb_top;
    import apd_pkg::*;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           start;
    t_apd_in        item;
    logic           busy;
    logic           res_valid;
    t_apd_out       res;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [VcW-1:0] cfg_data;
    int             mismatch_count;
    int             pending;

    // sender draws no gaps while set
    bit             steady_phase;
    // vertex count in force, as the block reads it
    int             live_count;

    // 10 ns clock
    always #5 clk = ~clk;

    all_pairs_hop_distance_eccentricity_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_item      (item),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    hop_eccentricity_checker checker_inst (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_start          (start),
        .i_item           (item),
        .i_busy           (busy),
        .i_res_valid      (res_valid),
        .i_res            (res),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    // one command beat; start is left high after acceptance so a gapless next beat follows
    task automatic push_beat(input t_cmd cmd, input int from_v, input int to_v);
        int      gap;
        t_apd_in beat;
        gap = steady_phase ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.cmd       = cmd;
        beat.edge_from = VcW'(from_v);
        beat.edge_to   = VcW'(to_v);
        start <= 1'b1;
        item  <= beat;
        do @(posedge clk); while (busy);
    endtask

    // drop start, wait for all results and for the block to go idle
    task automatic settle();
        start <= 1'b0;
        repeat (4) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // register write beat, only once the block is idle
    task automatic write_vertex_count(input int value);
        settle();
        repeat ($urandom_range(0, 14)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= VcW'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        live_count = (value < 1) ? 1 : (value > MaxVertices) ? MaxVertices : value;
    endtask

    // stimulus
    initial begin
        int path_order [MaxVertices-1];
        int tmp;
        int j;
        int a;
        start        = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        steady_phase = 1'b0;
        live_count   = MaxVertices;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // extreme endpoints, dropped edges, then the count shrinks with edges still stored
        write_vertex_count(MaxVertices);
        push_beat(CMD_EDGE, 1, 64);
        push_beat(CMD_EDGE, 64, 63);
        push_beat(CMD_EDGE, 0, 5);
        push_beat(CMD_EDGE, 5, 5);
        push_beat(CMD_EDGE, 65, 3);
        push_beat(CMD_EDGE, 127, 127);
        push_beat(CMD_EDGE, 3, 0);
        write_vertex_count(8);
        push_beat(CMD_EDGE, 1, 2);
        push_beat(CMD_EDGE, 2, 3);
        push_beat(CMD_EDGE, 4, 3);
        push_beat(CMD_EDGE, 8, 7);
        push_beat(CMD_EDGE, 9, 1);
        push_beat(CMD_RUN, 127, 0);

        // count of zero acts as a single vertex
        write_vertex_count(0);
        push_beat(CMD_EDGE, 1, 1);
        push_beat(CMD_EDGE, 1, 2);
        push_beat(CMD_RUN, 0, 127);

        // two vertices, then a run on the emptied matrix
        write_vertex_count(2);
        push_beat(CMD_EDGE, 2, 1);
        push_beat(CMD_RUN, 0, 0);
        steady_phase = 1'b1;
        push_beat(CMD_RUN, 85, 42);
        steady_phase = 1'b0;

        // random small graphs: chains and random pairs, some noise
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 0 || $urandom_range(0, 2) != 0) begin
                if ($urandom_range(0, 5) == 0) write_vertex_count($urandom_range(0, 1));
                else write_vertex_count($urandom_range(2, 12));
            end
            steady_phase = ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(3, 10)) begin
                a = $urandom_range(1, live_count);
                case ($urandom_range(0, 4))
                    0:       push_beat(CMD_EDGE, $urandom_range(0, 127), $urandom_range(0, 127));
                    1, 2:    push_beat(CMD_EDGE, a, (a % live_count) + 1);
                    default: push_beat(CMD_EDGE, a, $urandom_range(1, live_count));
                endcase
            end
            push_beat(CMD_RUN, $urandom_range(0, 127), $urandom_range(0, 127));
        end

        // saturated count: a shuffled path over all vertices gives the largest eccentricity
        write_vertex_count(127);
        steady_phase = ($urandom_range(0, 1) == 0);
        for (int i = 0; i < MaxVertices - 1; i++) path_order[i] = i + 1;
        for (int i = MaxVertices - 2; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = path_order[i];
            path_order[i] = path_order[j];
            path_order[j] = tmp;
        end
        foreach (path_order[i]) begin
            if ($urandom_range(0, 1) != 0) push_beat(CMD_EDGE, path_order[i], path_order[i] + 1);
            else push_beat(CMD_EDGE, path_order[i] + 1, path_order[i]);
        end
        push_beat(CMD_RUN, $urandom_range(0, 127), $urandom_range(0, 127));

        // drain and verdict
        settle();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit: stops the simulation with a fail verdict
    initial begin
        #15_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
